>>> rtl/interval_graph_register_coloring_defines.svh
// assertion macros for the interval graph register coloring block
// used by modules that carry concurrent checks; expects aclk and aresetn in scope
`ifndef INTERVAL_GRAPH_REGISTER_COLORING_DEFINES_SVH
`define INTERVAL_GRAPH_REGISTER_COLORING_DEFINES_SVH
`ifndef SYNTHESIS
`define IGRC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("igrc check failed");
`define IGRC_NEVER(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("igrc forbidden condition");
`else
`define IGRC_ASSERT(label, prop)
`define IGRC_NEVER(label, expr)
`endif
`endif

>>> rtl/igrc_pkg.sv
// shared constants and types for the interval graph register coloring block
// no dependencies
package igrc_pkg;
    localparam int TEMP_W     = 6;
    localparam int COLOR_W    = 4;
    localparam int NT_W       = 7;
    localparam int NC_W       = 5;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TEMPS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PHYS  = 8'd1;

    localparam logic [NT_W-1:0] NUM_TEMPS_RST = 7'd64;
    localparam logic [NC_W-1:0] NUM_PHYS_RST  = 5'd10;

    typedef struct packed {
        logic idle;
        logic clear;
    } run_ctrl_t;

    typedef struct packed {
        logic start_set;
        logic end_set;
    } iv_flags_t;
endpackage

>>> rtl/igrc_ram.sv
// generic single write port ram with registered read
// no dependencies
module igrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/igrc_intervals.sv
// live interval tables: first write and last use position per temporary
// depends on igrc_pkg and igrc_ram
module igrc_intervals #(
    parameter int MAX_TEMPS = 64,
    parameter int POS_BITS  = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                acc,
    input  logic                                is_comment,
    input  logic                                dest_valid,
    input  logic [igrc_pkg::TEMP_W-1:0]         dest_reg,
    input  logic                                src_is_reg,
    input  logic [igrc_pkg::TEMP_W-1:0]         src_reg,
    input  igrc_pkg::run_ctrl_t                 ctrl,
    input  logic [$clog2(MAX_TEMPS)-1:0]        rd_addr,
    output logic [POS_BITS-1:0]                 rd_start,
    output logic [POS_BITS-1:0]                 rd_end,
    output igrc_pkg::iv_flags_t                 rd_flags
);
    localparam int TB  = $clog2(MAX_TEMPS);
    localparam int IWX = igrc_pkg::TEMP_W + 1;

    logic                 dest_ok, src_ok;
    logic [TB-1:0]        dest_idx, src_idx;
    logic [MAX_TEMPS-1:0] start_set_reg, end_set_reg, src_newer_reg;
    logic [POS_BITS-1:0]  position_reg;
    logic                 sel_src_reg;
    igrc_pkg::iv_flags_t  flags_reg;
    logic [POS_BITS-1:0]  endd_rdata, ends_rdata;

    assign dest_ok  = acc && !is_comment && dest_valid &&
                      ({1'b0, dest_reg} < IWX'(MAX_TEMPS));
    assign src_ok   = acc && !is_comment && src_is_reg &&
                      ({1'b0, src_reg} < IWX'(MAX_TEMPS));
    assign dest_idx = dest_reg[TB-1:0];
    assign src_idx  = src_reg[TB-1:0];

    igrc_ram #(.WIDTH(POS_BITS), .DEPTH(MAX_TEMPS)) u_start_ram (
        .aclk(aclk), .we(dest_ok && !start_set_reg[dest_idx]), .waddr(dest_idx),
        .wdata(position_reg), .raddr(rd_addr), .rdata(rd_start)
    );

    igrc_ram #(.WIDTH(POS_BITS), .DEPTH(MAX_TEMPS)) u_end_dest_ram (
        .aclk(aclk), .we(dest_ok), .waddr(dest_idx),
        .wdata(position_reg), .raddr(rd_addr), .rdata(endd_rdata)
    );

    igrc_ram #(.WIDTH(POS_BITS), .DEPTH(MAX_TEMPS)) u_end_src_ram (
        .aclk(aclk), .we(src_ok), .waddr(src_idx),
        .wdata(position_reg), .raddr(rd_addr), .rdata(ends_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            start_set_reg <= '0;
            end_set_reg   <= '0;
            position_reg  <= '0;
        end else begin
            if (dest_ok) begin
                start_set_reg[dest_idx] <= 1'b1;
                end_set_reg[dest_idx]   <= 1'b1;
                src_newer_reg[dest_idx] <= 1'b0;
            end
            if (src_ok) begin
                end_set_reg[src_idx]   <= 1'b1;
                src_newer_reg[src_idx] <= 1'b1;
            end
            if (acc && (position_reg != '1)) begin
                position_reg <= position_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        flags_reg.start_set <= start_set_reg[rd_addr];
        flags_reg.end_set   <= end_set_reg[rd_addr];
        sel_src_reg         <= src_newer_reg[rd_addr];
    end

    assign rd_end   = sel_src_reg ? ends_rdata : endd_rdata;
    assign rd_flags = flags_reg;
endmodule

>>> rtl/igrc_alloc.sv
// allocation sequencer: graph build, highest degree removal, coloring, result output
// depends on igrc_pkg, igrc_ram and the assertion macro header
`include "interval_graph_register_coloring_defines.svh"
module igrc_alloc #(
    parameter int MAX_TEMPS  = 64,
    parameter int POS_BITS   = 12,
    parameter int MAX_COLORS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              go,
    input  logic [igrc_pkg::NT_W-1:0]         num_temps,
    input  logic [igrc_pkg::NC_W-1:0]         num_phys,
    output igrc_pkg::run_ctrl_t               ctrl,
    output logic [$clog2(MAX_TEMPS)-1:0]      iv_raddr,
    input  logic [POS_BITS-1:0]               iv_start,
    input  logic [POS_BITS-1:0]               iv_end,
    input  igrc_pkg::iv_flags_t               iv_flags,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [igrc_pkg::TEMP_W-1:0]       m_temp_index,
    output logic [igrc_pkg::COLOR_W-1:0]      m_color,
    output logic                              m_status,
    output logic                              m_last_result
);
    localparam int TB  = $clog2(MAX_TEMPS);
    localparam int NW  = $clog2(MAX_TEMPS + 1);
    localparam int DW  = TB;
    localparam int CB  = $clog2(MAX_COLORS);
    localparam int KW  = $clog2(MAX_COLORS + 1);
    localparam int IW  = igrc_pkg::TEMP_W;
    localparam int CW  = igrc_pkg::COLOR_W;
    localparam int NTX = igrc_pkg::NT_W + 1;
    localparam int NCX = igrc_pkg::NC_W + 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_B_RDI   = 4'd1;
    localparam logic [3:0] S_B_LATI  = 4'd2;
    localparam logic [3:0] S_B_SWEEP = 4'd3;
    localparam logic [3:0] S_R_ORDER = 4'd4;
    localparam logic [3:0] S_R_ROW   = 4'd5;
    localparam logic [3:0] S_R_SWEEP = 4'd6;
    localparam logic [3:0] S_C_RDO   = 4'd7;
    localparam logic [3:0] S_C_NODE  = 4'd8;
    localparam logic [3:0] S_C_ROW   = 4'd9;
    localparam logic [3:0] S_C_SWEEP = 4'd10;
    localparam logic [3:0] S_C_PICK  = 4'd11;
    localparam logic [3:0] S_O_RD    = 4'd12;
    localparam logic [3:0] S_O_LOAD  = 4'd13;
    localparam logic [3:0] S_O_WAIT  = 4'd14;

    logic [3:0]            state_reg, state_next;
    logic [NW-1:0]         n_reg, n_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [NW-1:0]         i_reg, i_next;
    logic [NW-1:0]         j_reg, j_next;
    logic [NW-1:0]         step_reg, step_next;
    logic                  pv_reg, pv_next;
    logic [TB-1:0]         pj_reg, pj_next;
    logic [POS_BITS-1:0]   ii_start_reg, ii_start_next;
    logic [POS_BITS-1:0]   ii_end_reg, ii_end_next;
    igrc_pkg::iv_flags_t   ii_flags_reg, ii_flags_next;
    logic [MAX_TEMPS-1:0]  row_acc_reg, row_acc_next;
    logic [DW-1:0]         deg_acc_reg, deg_acc_next;
    logic [DW-1:0]         best_deg_reg, best_deg_next;
    logic [TB-1:0]         best_idx_reg, best_idx_next;
    logic                  have_reg, have_next;
    logic [MAX_TEMPS-1:0]  active_reg, active_next;
    logic [MAX_TEMPS-1:0]  colored_reg, colored_next;
    logic [MAX_TEMPS-1:0]  row_reg, row_next;
    logic [TB-1:0]         node_reg, node_next;
    logic [MAX_COLORS-1:0] used_reg, used_next;
    logic                  m_valid_reg, m_valid_next;
    logic [IW-1:0]         m_temp_reg, m_temp_next;
    logic [CW-1:0]         m_color_reg, m_color_next;
    logic                  m_status_reg, m_status_next;
    logic                  m_last_reg, m_last_next;

    logic                  row_we, deg_we, order_we, color_we;
    logic [TB-1:0]         row_waddr, row_raddr, deg_waddr, order_waddr, order_raddr;
    logic [TB-1:0]         color_waddr, color_raddr;
    logic [MAX_TEMPS-1:0]  row_wdata, row_rdata;
    logic [DW-1:0]         deg_wdata, deg_rdata;
    logic [TB-1:0]         order_rdata;
    logic [CB-1:0]         color_wdata, color_rdata;

    logic                  issue, sweep_done, overlap, found;
    logic [DW-1:0]         dval;
    logic [CB-1:0]         pick_c;
    logic [NW-1:0]         n_clamp;
    logic [KW-1:0]         k_clamp;
    logic                  clear_pulse;
    logic [NW-1:0]         act_ones, col_ones;
    logic                  pick_ok;

    igrc_ram #(.WIDTH(MAX_TEMPS), .DEPTH(MAX_TEMPS)) u_row_ram (
        .aclk(aclk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
        .raddr(row_raddr), .rdata(row_rdata)
    );
    igrc_ram #(.WIDTH(DW), .DEPTH(MAX_TEMPS)) u_deg_ram (
        .aclk(aclk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
        .raddr(j_reg[TB-1:0]), .rdata(deg_rdata)
    );
    igrc_ram #(.WIDTH(TB), .DEPTH(MAX_TEMPS)) u_order_ram (
        .aclk(aclk), .we(order_we), .waddr(order_waddr), .wdata(best_idx_reg),
        .raddr(order_raddr), .rdata(order_rdata)
    );
    igrc_ram #(.WIDTH(CB), .DEPTH(MAX_TEMPS)) u_color_ram (
        .aclk(aclk), .we(color_we), .waddr(color_waddr), .wdata(color_wdata),
        .raddr(color_raddr), .rdata(color_rdata)
    );

    always_comb begin
        if (num_temps == '0) begin
            n_clamp = NW'(1);
        end else if ({1'b0, num_temps} > NTX'(MAX_TEMPS)) begin
            n_clamp = NW'(MAX_TEMPS);
        end else begin
            n_clamp = NW'(num_temps);
        end
        if (num_phys == '0) begin
            k_clamp = KW'(1);
        end else if ({1'b0, num_phys} > NCX'(MAX_COLORS)) begin
            k_clamp = KW'(MAX_COLORS);
        end else begin
            k_clamp = KW'(num_phys);
        end
    end

    assign issue      = (j_reg < n_reg);
    assign sweep_done = !issue && !pv_reg;

    assign overlap = ii_flags_reg.end_set && iv_flags.end_set &&
                     !(ii_flags_reg.start_set && (ii_start_reg > iv_end)) &&
                     !(iv_flags.start_set && (iv_start > ii_end_reg)) &&
                     (pj_reg != i_reg[TB-1:0]);

    always_comb begin
        found  = 1'b0;
        pick_c = '0;
        for (int c = MAX_COLORS - 1; c >= 0; c--) begin
            if ((KW'(c) < k_reg) && !used_reg[c]) begin
                found  = 1'b1;
                pick_c = CB'(c);
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        step_next     = step_reg;
        pv_next       = pv_reg;
        pj_next       = pj_reg;
        ii_start_next = ii_start_reg;
        ii_end_next   = ii_end_reg;
        ii_flags_next = ii_flags_reg;
        row_acc_next  = row_acc_reg;
        deg_acc_next  = deg_acc_reg;
        best_deg_next = best_deg_reg;
        best_idx_next = best_idx_reg;
        have_next     = have_reg;
        active_next   = active_reg;
        colored_next  = colored_reg;
        row_next      = row_reg;
        node_next     = node_reg;
        used_next     = used_reg;
        m_valid_next  = m_valid_reg;
        m_temp_next   = m_temp_reg;
        m_color_next  = m_color_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        clear_pulse   = 1'b0;
        dval          = deg_rdata;

        row_we      = 1'b0;
        row_waddr   = i_reg[TB-1:0];
        row_wdata   = row_acc_reg;
        row_raddr   = best_idx_reg;
        deg_we      = 1'b0;
        deg_waddr   = i_reg[TB-1:0];
        deg_wdata   = deg_acc_reg;
        order_we    = 1'b0;
        order_waddr = step_reg[TB-1:0];
        order_raddr = TB'(step_reg - 1'b1);
        color_we    = 1'b0;
        color_waddr = node_reg;
        color_wdata = pick_c;
        color_raddr = j_reg[TB-1:0];
        iv_raddr    = j_reg[TB-1:0];

        if (state_reg == S_B_SWEEP || state_reg == S_R_SWEEP ||
            state_reg == S_C_SWEEP) begin
            j_next  = issue ? (j_reg + 1'b1) : j_reg;
            pv_next = issue;
            pj_next = j_reg[TB-1:0];
        end

        case (state_reg)
            S_IDLE: begin
                if (go) begin
                    n_next       = n_clamp;
                    k_next       = k_clamp;
                    i_next       = '0;
                    have_next    = 1'b0;
                    colored_next = '0;
                    for (int t = 0; t < MAX_TEMPS; t++) begin
                        active_next[t] = (NW'(t) < n_clamp);
                    end
                    state_next   = S_B_RDI;
                end
            end
            S_B_RDI: begin
                iv_raddr   = i_reg[TB-1:0];
                state_next = S_B_LATI;
            end
            S_B_LATI: begin
                ii_start_next = iv_start;
                ii_end_next   = iv_end;
                ii_flags_next = iv_flags;
                row_acc_next  = '0;
                deg_acc_next  = '0;
                j_next        = '0;
                pv_next       = 1'b0;
                state_next    = S_B_SWEEP;
            end
            S_B_SWEEP: begin
                if (pv_reg && overlap) begin
                    row_acc_next[pj_reg] = 1'b1;
                    deg_acc_next         = deg_acc_reg + 1'b1;
                end
                if (sweep_done) begin
                    row_we = 1'b1;
                    deg_we = 1'b1;
                    if (!have_reg || (deg_acc_reg > best_deg_reg)) begin
                        best_deg_next = deg_acc_reg;
                        best_idx_next = i_reg[TB-1:0];
                        have_next     = 1'b1;
                    end
                    i_next = i_reg + 1'b1;
                    if ((i_reg + 1'b1) == n_reg) begin
                        step_next  = '0;
                        state_next = S_R_ORDER;
                    end else begin
                        state_next = S_B_RDI;
                    end
                end
            end
            S_R_ORDER: begin
                order_we                  = 1'b1;
                active_next[best_idx_reg] = 1'b0;
                row_raddr                 = best_idx_reg;
                state_next                = S_R_ROW;
            end
            S_R_ROW: begin
                row_next   = row_rdata & active_reg;
                have_next  = 1'b0;
                j_next     = '0;
                pv_next    = 1'b0;
                state_next = S_R_SWEEP;
            end
            S_R_SWEEP: begin
                if (pv_reg && active_reg[pj_reg]) begin
                    if (row_reg[pj_reg] && (deg_rdata != '0)) begin
                        dval      = deg_rdata - 1'b1;
                        deg_we    = 1'b1;
                        deg_waddr = pj_reg;
                        deg_wdata = dval;
                    end
                    if (!have_reg || (dval > best_deg_reg)) begin
                        best_deg_next = dval;
                        best_idx_next = pj_reg;
                        have_next     = 1'b1;
                    end
                end
                if (sweep_done) begin
                    if ((step_reg + 1'b1) == n_reg) begin
                        step_next  = n_reg;
                        state_next = S_C_RDO;
                    end else begin
                        step_next  = step_reg + 1'b1;
                        state_next = S_R_ORDER;
                    end
                end
            end
            S_C_RDO: begin
                state_next = S_C_NODE;
            end
            S_C_NODE: begin
                node_next  = order_rdata;
                row_raddr  = order_rdata;
                state_next = S_C_ROW;
            end
            S_C_ROW: begin
                row_next   = row_rdata & colored_reg;
                used_next  = '0;
                j_next     = '0;
                pv_next    = 1'b0;
                state_next = S_C_SWEEP;
            end
            S_C_SWEEP: begin
                if (pv_reg && row_reg[pj_reg]) begin
                    used_next[color_rdata] = 1'b1;
                end
                if (sweep_done) begin
                    state_next = S_C_PICK;
                end
            end
            S_C_PICK: begin
                i_next = '0;
                if (found) begin
                    color_we               = 1'b1;
                    colored_next[node_reg] = 1'b1;
                    step_next              = step_reg - 1'b1;
                    state_next             = (step_reg == NW'(1)) ? S_O_RD : S_C_RDO;
                end else begin
                    state_next = S_O_RD;
                end
            end
            S_O_RD: begin
                color_raddr = i_reg[TB-1:0];
                state_next  = S_O_LOAD;
            end
            S_O_LOAD: begin
                m_valid_next  = 1'b1;
                m_temp_next   = IW'(i_reg[TB-1:0]);
                m_color_next  = colored_reg[i_reg[TB-1:0]] ? CW'(color_rdata) : '0;
                m_status_next = !colored_reg[i_reg[TB-1:0]];
                m_last_next   = ((i_reg + 1'b1) == n_reg);
                state_next    = S_O_WAIT;
            end
            S_O_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    i_next       = i_reg + 1'b1;
                    if ((i_reg + 1'b1) == n_reg) begin
                        clear_pulse  = 1'b1;
                        colored_next = '0;
                        active_next  = '1;
                        state_next   = S_IDLE;
                    end else begin
                        state_next = S_O_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            active_reg  <= '1;
            colored_reg <= '0;
            have_reg    <= 1'b0;
            pv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            active_reg  <= active_next;
            colored_reg <= colored_next;
            have_reg    <= have_next;
            pv_reg      <= pv_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        k_reg        <= k_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        step_reg     <= step_next;
        pj_reg       <= pj_next;
        ii_start_reg <= ii_start_next;
        ii_end_reg   <= ii_end_next;
        ii_flags_reg <= ii_flags_next;
        row_acc_reg  <= row_acc_next;
        deg_acc_reg  <= deg_acc_next;
        best_deg_reg <= best_deg_next;
        best_idx_reg <= best_idx_next;
        row_reg      <= row_next;
        node_reg     <= node_next;
        used_reg     <= used_next;
        m_temp_reg   <= m_temp_next;
        m_color_reg  <= m_color_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign ctrl.idle     = (state_reg == S_IDLE);
    assign ctrl.clear    = clear_pulse;
    assign m_valid       = m_valid_reg;
    assign m_temp_index  = m_temp_reg;
    assign m_color       = m_color_reg;
    assign m_status      = m_status_reg;
    assign m_last_result = m_last_reg;

    assign act_ones = NW'($countones(active_reg));
    assign col_ones = NW'($countones(colored_reg));
    assign pick_ok  = (state_reg == S_C_PICK) && found;

    `IGRC_ASSERT(a_valid_in_wait, m_valid_reg |-> (state_reg == S_O_WAIT))
    `IGRC_NEVER(a_idle_no_result, (state_reg == S_IDLE) && m_valid_reg)
    `IGRC_ASSERT(a_removal_one, (state_reg == S_R_ORDER) |=> (act_ones == $past(act_ones) - 1'b1))
    `IGRC_ASSERT(a_color_one, pick_ok |=> (col_ones == $past(col_ones) + 1'b1))
endmodule

>>> rtl/interval_graph_register_coloring.sv
// Interval graph register coloring, top level.
// Input channel s_*: one instruction per transaction, accepted only while idle;
// a program streams in at one instruction per cycle.
// Config channel cfg_*: index 0 num_temps, index 1 num_phys, always ready;
// write only while idle. Result channel m_*: one transaction per temporary
// 0 .. n-1 after the instruction marked last, m_last_result on the final one.
// After the last instruction the sequencer runs out of block memories:
// graph build (one interval read per pair),
// removal (degree sweep per removed node),
// coloring (color sweep per node, stopping at a node with no free color),
// then one result at a time, each held through any m_ready stall.
// The sweeps run one read at a time, set by the single read port of each memory.
// A stalled receiver holds the current result; the sequencer waits.
// Reset (aresetn low, synchronous) clears the interval tables and the
// position counter and restores num_temps 64 and num_phys 10.
// Memory contents need no clearing: per-entry valid bits cover them.
// depends on igrc_pkg, igrc_intervals, igrc_alloc
module interval_graph_register_coloring #(
    parameter int MAX_TEMPS  = 64,
    parameter int POS_BITS   = 12,
    parameter int MAX_COLORS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_is_comment,
    input  logic                                s_dest_valid,
    input  logic [igrc_pkg::TEMP_W-1:0]         s_dest_reg,
    input  logic                                s_src_is_reg,
    input  logic [igrc_pkg::TEMP_W-1:0]         s_src_reg,
    input  logic                                s_is_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [igrc_pkg::TEMP_W-1:0]         m_temp_index,
    output logic [igrc_pkg::COLOR_W-1:0]        m_color,
    output logic                                m_status,
    output logic                                m_last_result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [igrc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [igrc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    localparam int TB = $clog2(MAX_TEMPS);

    logic [igrc_pkg::NT_W-1:0] num_temps_reg;
    logic [igrc_pkg::NC_W-1:0] num_phys_reg;
    igrc_pkg::run_ctrl_t       ctrl;
    logic                      acc;
    logic [TB-1:0]             iv_raddr;
    logic [POS_BITS-1:0]       iv_start, iv_end;
    igrc_pkg::iv_flags_t       iv_flags;

    assign s_ready   = ctrl.idle;
    assign cfg_ready = 1'b1;
    assign acc       = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_temps_reg <= igrc_pkg::NUM_TEMPS_RST;
            num_phys_reg  <= igrc_pkg::NUM_PHYS_RST;
        end else if (cfg_valid) begin
            if (cfg_index == igrc_pkg::CFG_NUM_TEMPS) begin
                num_temps_reg <= cfg_data[igrc_pkg::NT_W-1:0];
            end else if (cfg_index == igrc_pkg::CFG_NUM_PHYS) begin
                num_phys_reg <= cfg_data[igrc_pkg::NC_W-1:0];
            end
        end
    end

    igrc_intervals #(.MAX_TEMPS(MAX_TEMPS), .POS_BITS(POS_BITS)) u_intervals (
        .aclk(aclk), .aresetn(aresetn), .acc(acc),
        .is_comment(s_is_comment), .dest_valid(s_dest_valid), .dest_reg(s_dest_reg),
        .src_is_reg(s_src_is_reg), .src_reg(s_src_reg), .ctrl(ctrl),
        .rd_addr(iv_raddr), .rd_start(iv_start), .rd_end(iv_end), .rd_flags(iv_flags)
    );

    igrc_alloc #(
        .MAX_TEMPS(MAX_TEMPS), .POS_BITS(POS_BITS), .MAX_COLORS(MAX_COLORS)
    ) u_alloc (
        .aclk(aclk), .aresetn(aresetn), .go(acc && s_is_last),
        .num_temps(num_temps_reg), .num_phys(num_phys_reg), .ctrl(ctrl),
        .iv_raddr(iv_raddr), .iv_start(iv_start), .iv_end(iv_end), .iv_flags(iv_flags),
        .m_valid(m_valid), .m_ready(m_ready), .m_temp_index(m_temp_index),
        .m_color(m_color), .m_status(m_status), .m_last_result(m_last_result)
    );
endmodule

>>> tb/igrc_checker.sv
// checker for interval_graph_register_coloring: watches the config, instruction and
// result channels, predicts the coloring of each program and compares every result
// depends on igrc_pkg
module igrc_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_is_comment,
    input  logic                            s_dest_valid,
    input  logic [igrc_pkg::TEMP_W-1:0]     s_dest_reg,
    input  logic                            s_src_is_reg,
    input  logic [igrc_pkg::TEMP_W-1:0]     s_src_reg,
    input  logic                            s_is_last,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [igrc_pkg::TEMP_W-1:0]     m_temp_index,
    input  logic [igrc_pkg::COLOR_W-1:0]    m_color,
    input  logic                            m_status,
    input  logic                            m_last_result,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [igrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [igrc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending
);
    localparam int NTEMP = 64;
    localparam logic [11:0] POS_TOP = 12'hfff;

    typedef struct {
        logic [igrc_pkg::TEMP_W-1:0]  temp;
        logic [igrc_pkg::COLOR_W-1:0] color;
        logic                         status;
        logic                         last;
    } coloring_t;

    coloring_t expected_colorings[$];

    logic [igrc_pkg::NT_W-1:0] cur_num_temps;
    logic [igrc_pkg::NC_W-1:0] cur_num_phys;
    logic [11:0]      pos;
    logic [11:0]      first_pos [NTEMP];
    logic [11:0]      last_pos  [NTEMP];
    logic [NTEMP-1:0] first_seen;
    logic [NTEMP-1:0] last_seen;

    assign pending = expected_colorings.size();

    function automatic bit live_overlap(int i, int j);
        if (!last_seen[i] || !last_seen[j]) return 0;
        if (first_seen[i] && first_pos[i] > last_pos[j]) return 0;
        if (first_seen[j] && first_pos[j] > last_pos[i]) return 0;
        return 1;
    endfunction

    task automatic clear_program();
        pos = '0;
        first_seen = '0;
        last_seen = '0;
        for (int i = 0; i < NTEMP; i++) begin
            first_pos[i] = '0;
            last_pos[i] = '0;
        end
    endtask

    task automatic predict_coloring();
        int n;
        int k;
        int pick;
        int node;
        int c;
        bit found;
        logic [NTEMP-1:0] adj [NTEMP];
        int deg [NTEMP];
        int order [NTEMP];
        int cmap [NTEMP];
        logic [NTEMP-1:0] active;
        logic [NTEMP-1:0] colored;
        logic [31:0] used;
        coloring_t r;
        n = cur_num_temps;
        k = cur_num_phys;
        if (n < 1) n = 1;
        if (n > NTEMP) n = NTEMP;
        if (k < 1) k = 1;
        if (k > 16) k = 16;
        for (int i = 0; i < n; i++) begin
            adj[i] = '0;
            deg[i] = 0;
            cmap[i] = 0;
            for (int j = 0; j < n; j++)
                if (j != i && live_overlap(i, j)) begin
                    adj[i][j] = 1'b1;
                    deg[i]++;
                end
        end
        active = '0;
        for (int i = 0; i < n; i++) active[i] = 1'b1;
        for (int s = 0; s < n; s++) begin
            pick = -1;
            for (int i = 0; i < n; i++)
                if (active[i] && (pick < 0 || deg[i] > deg[pick])) pick = i;
            order[s] = pick;
            active[pick] = 1'b0;
            for (int j = 0; j < n; j++)
                if (adj[pick][j] && active[j] && deg[j] > 0) deg[j]--;
            deg[pick] = 0;
        end
        colored = '0;
        for (int s = n - 1; s >= 0; s--) begin
            node = order[s];
            used = '0;
            for (int j = 0; j < n; j++)
                if (adj[node][j] && colored[j]) used[cmap[j]] = 1'b1;
            found = 0;
            for (c = 0; c < k; c++)
                if (!used[c]) begin
                    found = 1;
                    break;
                end
            if (!found) break;
            cmap[node] = c;
            colored[node] = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            r.temp = i[igrc_pkg::TEMP_W-1:0];
            r.color = colored[i] ? cmap[i][igrc_pkg::COLOR_W-1:0] : '0;
            r.status = !colored[i];
            r.last = (i == n - 1);
            expected_colorings.push_back(r);
        end
        clear_program();
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        cur_num_temps = igrc_pkg::NUM_TEMPS_RST;
        cur_num_phys = igrc_pkg::NUM_PHYS_RST;
        clear_program();
    end

    always @(posedge aclk) begin
        coloring_t want;
        if (!aresetn) begin
            cur_num_temps = igrc_pkg::NUM_TEMPS_RST;
            cur_num_phys = igrc_pkg::NUM_PHYS_RST;
            clear_program();
            expected_colorings.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == igrc_pkg::CFG_NUM_TEMPS)
                    cur_num_temps = cfg_data[igrc_pkg::NT_W-1:0];
                else if (cfg_index == igrc_pkg::CFG_NUM_PHYS)
                    cur_num_phys = cfg_data[igrc_pkg::NC_W-1:0];
            end
            if (m_valid && m_ready) begin
                if (expected_colorings.size() == 0) begin
                    report("unexpected result transaction, temp", m_temp_index, -1);
                end else begin
                    want = expected_colorings.pop_front();
                    if (m_temp_index !== want.temp) report("temp_index", m_temp_index, want.temp);
                    if (m_color !== want.color) report("color", m_color, want.color);
                    if (m_status !== want.status) report("status", m_status, want.status);
                    if (m_last_result !== want.last)
                        report("last_result", m_last_result, want.last);
                end
            end
            if (s_valid && s_ready) begin
                if (!s_is_comment) begin
                    if (s_dest_valid) begin
                        if (!first_seen[s_dest_reg]) begin
                            first_pos[s_dest_reg] = pos;
                            first_seen[s_dest_reg] = 1'b1;
                        end
                        last_pos[s_dest_reg] = pos;
                        last_seen[s_dest_reg] = 1'b1;
                    end
                    if (s_src_is_reg) begin
                        last_pos[s_src_reg] = pos;
                        last_seen[s_src_reg] = 1'b1;
                    end
                end
                if (pos != POS_TOP) pos = pos + 1'b1;
                if (s_is_last) predict_coloring();
            end
        end
    end
endmodule

>>> tb/tb_top.sv
// top of the interval_graph_register_coloring testbench: clock, reset, instruction
// and config stimulus, receiver stalls and the verdict
// depends on igrc_pkg, igrc_checker and the block itself
module tb_top;
    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic                              s_is_comment;
    logic                              s_dest_valid;
    logic [igrc_pkg::TEMP_W-1:0]       s_dest_reg;
    logic                              s_src_is_reg;
    logic [igrc_pkg::TEMP_W-1:0]       s_src_reg;
    logic                              s_is_last;
    logic                              m_valid;
    logic                              m_ready;
    logic [igrc_pkg::TEMP_W-1:0]       m_temp_index;
    logic [igrc_pkg::COLOR_W-1:0]      m_color;
    logic                              m_status;
    logic                              m_last_result;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [igrc_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [igrc_pkg::CFG_DATA_W-1:0]   cfg_data;
    int                                fail_count;
    int                                pending;
    int                                send_idle_pct;
    int                                recv_idle_pct;
    int                                instr_sent;

    interval_graph_register_coloring dut (.*);
    igrc_checker chk (.*);

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk)
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    task automatic send_instr(bit cm, bit dv, logic [5:0] d, bit sr, logic [5:0] s, bit last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_is_comment <= cm;
        s_dest_valid <= dv;
        s_dest_reg <= d;
        s_src_is_reg <= sr;
        s_src_reg <= s;
        s_is_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        instr_sent++;
    endtask

    // hold the sender until every coloring result is back, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [igrc_pkg::CFG_IDX_W-1:0] idx,
                             logic [igrc_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_program(int len, int span);
        for (int i = 0; i < len; i++)
            send_instr($urandom_range(0, 7) == 0, $urandom_range(0, 3) != 0,
                ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, span)),
                1'($urandom_range(0, 1)),
                ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, span)),
                i == len - 1);
        drain();
    endtask

    task automatic random_config(output int nt);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) nt = 64;
        else if (pick == 1) nt = $urandom_range(65, 255);
        else if (pick == 2) nt = 0;
        else nt = $urandom_range(1, 16);
        write_cfg(igrc_pkg::CFG_NUM_TEMPS, 8'(nt));
        write_cfg(igrc_pkg::CFG_NUM_PHYS, 8'($urandom_range(0, 255)));
        nt = nt & 127;
        if (nt < 1) nt = 1;
        if (nt > 64) nt = 64;
    endtask

    initial begin
        int nt;
        int target;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_is_comment <= 1'b0;
        s_dest_valid <= 1'b0;
        s_dest_reg <= '0;
        s_src_is_reg <= 1'b0;
        s_src_reg <= '0;
        s_is_last <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= igrc_pkg::CFG_NUM_TEMPS;
        cfg_data <= '0;
        send_idle_pct = 25;
        recv_idle_pct = 60;
        instr_sent = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset config, field extremes
        send_instr(0, 1, 6'd0, 0, 6'd0, 0);
        send_instr(0, 1, 6'd63, 1, 6'd0, 0);
        send_instr(1, 1, 6'd63, 1, 6'd63, 0);
        send_instr(0, 1, 6'd5, 1, 6'd63, 0);
        send_instr(0, 0, 6'd63, 1, 6'd5, 0);
        send_instr(0, 1, 6'd1, 1, 6'd1, 0);
        send_instr(0, 1, 6'd2, 1, 6'd1, 1);
        drain();
        // clique of three with one color: allocation fails
        write_cfg(igrc_pkg::CFG_NUM_TEMPS, 8'd3);
        write_cfg(igrc_pkg::CFG_NUM_PHYS, 8'd1);
        for (int i = 0; i < 3; i++) send_instr(0, 1, 6'(i), 0, 6'd0, 0);
        for (int i = 0; i < 3; i++) send_instr(0, 0, 6'd0, 1, 6'(i), i == 2);
        drain();
        // zero registers clamp up, lone last comment
        write_cfg(igrc_pkg::CFG_NUM_TEMPS, 8'd0);
        write_cfg(igrc_pkg::CFG_NUM_PHYS, 8'd0);
        send_instr(1, 1, 6'd0, 1, 6'd0, 1);
        drain();
        // oversized registers clamp down
        write_cfg(igrc_pkg::CFG_NUM_TEMPS, 8'd127);
        write_cfg(igrc_pkg::CFG_NUM_PHYS, 8'd31);
        random_program(8, 63);
        write_cfg(igrc_pkg::CFG_NUM_TEMPS, 8'd64);
        write_cfg(igrc_pkg::CFG_NUM_PHYS, 8'd16);
        random_program(6, 63);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 60 : 0;
            recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 25 : 0;
            target = instr_sent + 110;
            while (instr_sent < target) begin
                random_config(nt);
                random_program($urandom_range(1, 24), nt + 1);
            end
        end

        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("interval_graph_register_coloring regression: pass");
        else
            $display("interval_graph_register_coloring regression: fail");
        $finish;
    end

    initial begin
        #40000000;
        $display("interval_graph_register_coloring regression: fail");
        $finish;
    end
endmodule
